### src/gidh_pkg.sv
// shared types, constants and helpers for the gray image difference block
// no dependencies
package gidh_pkg;

  localparam int MAX_DIM    = 4096;
  localparam int DIM_W      = $clog2(MAX_DIM) + 1;   // size registers, exclusive bounds
  localparam int COORD_W    = $clog2(MAX_DIM);       // column and row
  localparam int PIX_W      = 8;
  localparam int CNT_W      = 25;
  localparam int TOT_W      = 2 * COORD_W + 1;       // width * height
  localparam int Q_BITS     = 16;
  localparam int FRAC_W     = Q_BITS + 1;
  localparam int STEP_W     = $clog2(Q_BITS);
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam logic [CNT_W-1:0]  COUNT_MAX = {CNT_W{1'b1}};
  localparam logic [FRAC_W-1:0] FRAC_ONE  = FRAC_W'(1) << Q_BITS;
  localparam logic [PIX_W-1:0]  PIX_FULL  = {PIX_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

  typedef struct packed {
    logic [PIX_W-1:0]   out_red;
    logic [PIX_W-1:0]   out_green;
    logic [PIX_W-1:0]   out_blue;
    logic               pixel_differs;
    logic               frame_done;
    logic [CNT_W-1:0]   diff_count;
    logic               box_valid;
    logic [COORD_W-1:0] box_left;
    logic [COORD_W-1:0] box_top;
    logic [DIM_W-1:0]   box_right;
    logic [DIM_W-1:0]   box_bottom;
    logic [FRAC_W-1:0]  diff_fraction;
  } result_t;

  typedef struct packed {
    logic load;         // take the input beat, update accumulators
    logic mul;          // register width * height
    logic div_init;     // load remainder and saturation flag
    logic step;         // one quotient bit
    logic sel_pending;  // queue takes the frame-end result
    logic push;         // write a result into the output queue
  } cmd_t;

  typedef struct packed {
    logic done;         // current input beat closes the frame
    logic last_step;    // final quotient bit this cycle
  } status_t;

  // zero acts as one, anything above the limit acts as the limit
  function automatic logic [DIM_W-1:0] eff_size(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) r = DIM_W'(1);
    else if (v > DIM_W'(MAX_DIM)) r = DIM_W'(MAX_DIM);
    else r = v;
    return r;
  endfunction

endpackage

### src/gray_image_diff_highlight_bbox.sv
// top level of the gray image difference highlighter with bounding box
// depends on gidh_pkg, gidh_ctrl, gidh_datapath, gidh_outq
//
// channel   direction  handshake             payload
// cfg       in         cfg_write             cfg_index, cfg_data
// in        in         in_valid / in_stall   orig_pixel, edit_pixel
// out       out        out_valid / out_stall out_red .. diff_fraction
//
// ordinary pixel beats are taken one per cycle while the output queue has room
// the last pixel of a frame holds the input through the size multiply, the divider
// setup, the bit-serial fraction divider and the push of the result into the queue
// a two-entry output queue lets input continue while a result waits
// rst is synchronous; it clears the position, accumulators, registers and queue
module gray_image_diff_highlight_bbox (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [gidh_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gidh_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [gidh_pkg::PIX_W-1:0]         orig_pixel,
  input  logic [gidh_pkg::PIX_W-1:0]         edit_pixel,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [gidh_pkg::PIX_W-1:0]         out_red,
  output logic [gidh_pkg::PIX_W-1:0]         out_green,
  output logic [gidh_pkg::PIX_W-1:0]         out_blue,
  output logic                               pixel_differs,
  output logic                               frame_done,
  output logic [gidh_pkg::CNT_W-1:0]         diff_count,
  output logic                               box_valid,
  output logic [gidh_pkg::COORD_W-1:0]       box_left,
  output logic [gidh_pkg::COORD_W-1:0]       box_top,
  output logic [gidh_pkg::DIM_W-1:0]         box_right,
  output logic [gidh_pkg::DIM_W-1:0]         box_bottom,
  output logic [gidh_pkg::FRAC_W-1:0]        diff_fraction
);
  import gidh_pkg::*;

  cmd_t    cmd;
  status_t status;
  result_t result, head;
  logic    full;

  gidh_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .full     (full),
    .status   (status),
    .cmd      (cmd)
  );

  gidh_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .orig_pixel (orig_pixel),
    .edit_pixel (edit_pixel),
    .cmd        (cmd),
    .status     (status),
    .result     (result)
  );

  gidh_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (cmd.push),
    .wdata     (result),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .rdata     (head)
  );

  assign out_red       = head.out_red;
  assign out_green     = head.out_green;
  assign out_blue      = head.out_blue;
  assign pixel_differs = head.pixel_differs;
  assign frame_done    = head.frame_done;
  assign diff_count    = head.diff_count;
  assign box_valid     = head.box_valid;
  assign box_left      = head.box_left;
  assign box_top       = head.box_top;
  assign box_right     = head.box_right;
  assign box_bottom    = head.box_bottom;
  assign diff_fraction = head.diff_fraction;

endmodule

### src/gidh_outq.sv
// two-entry result queue in front of the output channel
// depends on gidh_pkg
module gidh_outq (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  gidh_pkg::result_t wdata,
  output logic             full,
  output logic             out_valid,
  input  logic             out_stall,
  output gidh_pkg::result_t rdata
);
  import gidh_pkg::*;

  result_t    mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign pop       = out_valid && !out_stall;
  assign out_valid = (count != 2'd0);
  assign full      = (count == 2'd2);
  assign rdata     = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

### src/gidh_datapath.sv
// pixel compare, frame accumulators, config registers and fraction divider
// depends on gidh_pkg
module gidh_datapath (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [gidh_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gidh_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic [gidh_pkg::PIX_W-1:0]         orig_pixel,
  input  logic [gidh_pkg::PIX_W-1:0]         edit_pixel,
  input  gidh_pkg::cmd_t                     cmd,
  output gidh_pkg::status_t                  status,
  output gidh_pkg::result_t                  result
);
  import gidh_pkg::*;

  logic [PIX_W-1:0]   tolerance;
  logic [DIM_W-1:0]   image_width;
  logic [DIM_W-1:0]   image_height;

  logic [COORD_W-1:0] column, row;
  logic [CNT_W-1:0]   differ_total;
  logic               any_differ;
  logic [COORD_W-1:0] min_column, min_row, max_column, max_row;

  logic [DIM_W-1:0]   eff_w, eff_h, lim_col, lim_row;
  logic [PIX_W-1:0]   delta;
  logic               differs, row_end, done;
  logic [CNT_W-1:0]   differ_total_next;
  logic [COORD_W-1:0] min_column_next, min_row_next, max_column_next, max_row_next;
  result_t            immediate, pending;

  logic [2*DIM_W-1:0] prod;
  logic [TOT_W-1:0]   total;
  logic [CNT_W-1:0]   rem;
  logic [CNT_W:0]     rem2;
  logic [Q_BITS-1:0]  quot;
  logic               sat;
  logic [STEP_W-1:0]  step_cnt;
  logic               step_fits;

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance    <= '0;
      image_width  <= DIM_W'(1);
      image_height <= DIM_W'(1);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_TOLERANCE:    tolerance    <= cfg_data[PIX_W-1:0];
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[DIM_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  assign eff_w   = eff_size(image_width);
  assign eff_h   = eff_size(image_height);
  assign lim_col = eff_w - DIM_W'(1);
  assign lim_row = eff_h - DIM_W'(1);

  assign delta   = (orig_pixel > edit_pixel) ? orig_pixel - edit_pixel
                                             : edit_pixel - orig_pixel;
  assign differs = delta > tolerance;
  // passing the last column also ends a row, for widths changed mid-frame
  assign row_end = {1'b0, column} >= lim_col;
  assign done    = row_end && ({1'b0, row} >= lim_row);

  always_comb begin
    differ_total_next = differ_total;
    min_column_next   = min_column;
    min_row_next      = min_row;
    max_column_next   = max_column;
    max_row_next      = max_row;
    if (differs) begin
      if (differ_total != COUNT_MAX) differ_total_next = differ_total + CNT_W'(1);
      if (!any_differ) begin
        min_column_next = column;
        max_column_next = column;
        min_row_next    = row;
        max_row_next    = row;
      end else begin
        if (column < min_column) min_column_next = column;
        if (column > max_column) max_column_next = column;
        if (row < min_row) min_row_next = row;
        if (row > max_row) max_row_next = row;
      end
    end
  end

  always_comb begin
    immediate = '0;
    immediate.pixel_differs = differs;
    if (differs) begin
      immediate.out_red = PIX_FULL;
    end else begin
      immediate.out_red   = orig_pixel;
      immediate.out_green = orig_pixel;
      immediate.out_blue  = orig_pixel;
    end
    if (done) begin
      immediate.frame_done = 1'b1;
      immediate.diff_count = differ_total_next;
      immediate.box_valid  = any_differ || differs;
      if (any_differ || differs) begin
        immediate.box_left   = min_column_next;
        immediate.box_top    = min_row_next;
        immediate.box_right  = {1'b0, max_column_next} + DIM_W'(1);
        immediate.box_bottom = {1'b0, max_row_next} + DIM_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column       <= '0;
      row          <= '0;
      differ_total <= '0;
      any_differ   <= 1'b0;
      min_column   <= '0;
      min_row      <= '0;
      max_column   <= '0;
      max_row      <= '0;
    end else if (cmd.load) begin
      if (done) begin
        column       <= '0;
        row          <= '0;
        differ_total <= '0;
        any_differ   <= 1'b0;
        min_column   <= '0;
        min_row      <= '0;
        max_column   <= '0;
        max_row      <= '0;
      end else begin
        differ_total <= differ_total_next;
        any_differ   <= any_differ || differs;
        min_column   <= min_column_next;
        min_row      <= min_row_next;
        max_column   <= max_column_next;
        max_row      <= max_row_next;
        if (row_end) begin
          column <= '0;
          row    <= row + COORD_W'(1);
        end else begin
          column <= column + COORD_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) pending <= immediate;
  end

  // restoring division of count * 2^16 by the pixel total, one bit a cycle
  assign prod      = eff_w * eff_h;
  assign rem2      = {rem, 1'b0};
  assign step_fits = rem2 >= {{(CNT_W + 1 - TOT_W){1'b0}}, total};

  always_ff @(posedge clk) begin
    if (cmd.mul) total <= prod[TOT_W-1:0];
    if (cmd.div_init) begin
      // a count at or above the total saturates at one
      sat      <= pending.diff_count >= CNT_W'(total);
      rem      <= pending.diff_count;
      quot     <= '0;
      step_cnt <= '0;
    end else if (cmd.step) begin
      rem      <= step_fits ? rem2[CNT_W-1:0] - CNT_W'(total) : rem2[CNT_W-1:0];
      quot     <= {quot[Q_BITS-2:0], step_fits};
      step_cnt <= step_cnt + STEP_W'(1);
    end
  end

  assign status.done      = done;
  assign status.last_step = (step_cnt == STEP_W'(Q_BITS - 1));

  always_comb begin
    if (cmd.sel_pending) begin
      result = pending;
      result.diff_fraction = sat ? FRAC_ONE : {1'b0, quot};
    end else begin
      result = immediate;
    end
  end

endmodule

### src/gidh_ctrl.sv
// sequencer: pixel beats, frame-end multiply and divide, result hand-off
// depends on gidh_pkg
module gidh_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              full,
  input  gidh_pkg::status_t status,
  output gidh_pkg::cmd_t    cmd
);
  import gidh_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_CMP  = 5'b00100,
    S_DIV  = 5'b01000,
    S_PUSH = 5'b10000
  } state_t;

  state_t state, state_next;
  logic   accept;

  assign in_stall = (state != S_IDLE) || full;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.load = 1'b1;
          if (status.done) state_next = S_MUL;
          else cmd.push = 1'b1;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_CMP;
      end
      S_CMP: begin
        cmd.div_init = 1'b1;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.step = 1'b1;
        if (status.last_step) state_next = S_PUSH;
      end
      S_PUSH: begin
        cmd.sel_pending = 1'b1;
        if (!full) begin
          cmd.push   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

`ifndef SYNTHESIS
  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    accept |-> state == S_IDLE)
    else $error("input beat taken outside idle");
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> !full)
    else $error("result pushed into full queue");
  a_frame_end_stall: assert property (@(posedge clk) disable iff (rst)
    accept && status.done |=> in_stall && state == S_MUL)
    else $error("frame end did not start the divider");
  a_div_exit: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV && status.last_step |=> state == S_PUSH)
    else $error("divider did not hand off the result");
`endif

endmodule
